/* hw/rtl/smpq_pkg.sv */
// Shared codes and types for the sorted minimum priority queue.
package smpq_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] entry_t;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

/* hw/rtl/smpq_cell.sv */
// One storage cell of the sorted row: holds one entry and shifts with its neighbours.
module smpq_cell (
  input  logic                clk,
  input  smpq_pkg::cell_ctl_t ctl,
  input  smpq_pkg::entry_t    data,
  input  logic                occ,
  input  smpq_pkg::entry_t    left_entry,
  input  logic                left_lt,
  input  smpq_pkg::entry_t    right_entry,
  output smpq_pkg::entry_t    entry,
  output logic                lt
);
  import smpq_pkg::*;

  entry_t entry_next;

  // The row is ascending from cell 0, so the cells with lt set form a prefix.
  assign lt = occ && (entry < data);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (lt) begin
        entry_next = entry;
      end else if (left_lt) begin
        // First cell not below the new value: the new value lands here,
        // ahead of any equal entries.
        entry_next = data;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* hw/rtl/sorted_min_priority_queue_unit.sv */
// Top level of the sorted minimum priority queue built as a row of shift cells.
//
//   channel   handshake          payload
//   command   start / busy       action, data
//   result    done (strobe)      value, status, count
//
// Every command is taken as it arrives and its result appears on the cycle after,
// so a new command may follow in every cycle; busy never rises. Each cell compares
// its own entry with the new value, so an insert or remove needs no search of the row.
// Reset clears the fill count and the result strobe; the entries are not cleared.
// The receiver cannot stall: done lasts exactly one cycle per command.
module sorted_min_priority_queue_unit #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic signed [31:0] data,
  output logic        done,
  output logic signed [31:0] value,
  output logic [1:0]  status,
  output logic [7:0]  count
);
  import smpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  entry_t        ent [DEPTH];
  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] occ;
  cell_ctl_t     ctl;
  logic          full;
  logic          empty;
  logic          is_read;

  assign busy    = 1'b0;
  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign is_read = (action == ACT_REMOVE) || (action == ACT_PEEK);

  assign ctl.ins = start && (action == ACT_INSERT) && !full;
  assign ctl.rem = start && (action == ACT_REMOVE) && !empty;

  always_comb begin
    fill_next = fill;
    if (ctl.ins) begin
      fill_next = fill + CW'(1);
    end else if (ctl.rem) begin
      fill_next = fill - CW'(1);
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      entry_t left_entry;
      logic   left_lt;
      entry_t right_entry;

      assign occ[g] = (fill > CW'(g));

      if (g == 0) begin : g_first
        assign left_entry = data;
        assign left_lt    = 1'b1;
      end else begin : g_inner
        assign left_entry = ent[g-1];
        assign left_lt    = lt[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
        assign right_entry = ent[g];
      end else begin : g_mid
        assign right_entry = ent[g+1];
      end

      smpq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .data        (data),
        .occ         (occ[g]),
        .left_entry  (left_entry),
        .left_lt     (left_lt),
        .right_entry (right_entry),
        .entry       (ent[g]),
        .lt          (lt[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= start;
    end
  end

  // Result payload; the smallest entry always sits in cell 0.
  always_ff @(posedge clk) begin
    value  <= '0;
    status <= ST_OK;
    count  <= 8'(fill_next);
    if (start) begin
      if (action == ACT_INSERT && full) begin
        status <= ST_FULL;
      end else if (is_read && empty) begin
        status <= ST_EMPTY;
      end else if (is_read) begin
        value <= ent[0];
      end
    end
  end

endmodule
